// ===== hdl/rphs_pkg.sv =====
// package for the resident page hash set with clock sweep
// types, constants and the 64-bit mix used by the top level; no dependencies
package rphs_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int MAX_BATCH  = 64;
  localparam int BATCH_BITS = 7;

  localparam logic [63:0] SLOT_EMPTY = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SLOT_TOMB  = 64'hFFFF_FFFF_FFFF_FFFE;
  localparam logic [63:0] MIX_M      = 64'hc6a4_a793_5bd1_e995;
  localparam logic [63:0] MIX_SEED   = 64'h8445_d61a_4e77_4912 ^ (64'd8 * MIX_M);

  typedef enum logic [1:0] {
    OP_CONTAINS = 2'd0,
    OP_INSERT   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_SWEEP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NO   = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_FOLD, S_PROBE_RD, S_PROBE, S_WRITE, S_SWEEP_RD, S_SWEEP,
    S_TAIL
  } state_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic [63:0]           page_number;
    logic [BATCH_BITS-1:0] batch_size;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] candidate_page;
    logic        has_candidate;
    logic        last;
  } out_word_t;

endpackage

// ===== hdl/resident_page_hash_set_clock.sv =====
// resident page hash set with linear probing, tombstones and clock sweep
// depends on rphs_pkg; holds the slot memory and the operation sequencer
//
// usage: pulse start with in_word while busy is low. busy stays high until the
// last result word is strobed on out_word with out_valid for one cycle and is
// low in that cycle. contains, insert and remove give one word; a sweep gives
// one word per occupied slot scanned (at most 64) or one word with no candidate.
// the hash runs four 64x64 products, each four 32x32 partial-product steps plus
// one fold step; each probed slot then passes a read and a check state through
// the registered-read slot memory, and an insert adds a write state. a sweep
// passes a read and a check state per scanned slot, plus a tail state when the
// last scanned slot is occupied and an earlier candidate is pending. a reserved
// page or a zero batch answers straight from idle, with busy staying low. after
// reset all 1024 slots are swept to empty, one slot a cycle, with busy high.
// the receiver cannot stall: every out_valid cycle is a word.
module resident_page_hash_set_clock (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rphs_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output rphs_pkg::out_word_t  out_word
);
  import rphs_pkg::*;

  logic [63:0] mem [SLOT_COUNT];
  logic [63:0] rd_data_r;
  logic [SLOT_BITS-1:0] rd_addr, wr_addr;
  logic        rd_en, wr_en;
  logic [63:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  state_t state_r, state_nxt;
  logic [SLOT_BITS-1:0] ptr_r, ptr_nxt, hand_r, hand_nxt, free_r, free_nxt;
  logic [SLOT_BITS:0]   cnt_r, cnt_nxt;
  logic                 have_free_r, have_free_nxt;
  logic                 found_r, found_nxt;
  logic [1:0]           op_r, op_nxt;
  logic [63:0]          pid_r, pid_nxt;
  logic [63:0]          acc_r, acc_nxt, h_r, h_nxt;
  logic [2:0]           mstep_r, mstep_nxt;
  logic [1:0]           part_r, part_nxt;
  logic [63:0]          mop_r, mop_nxt;
  logic                 ov_r, ov_nxt;
  out_word_t            ow_r, ow_nxt;

  // multiply operand by MIX_M, one 32x32 partial product per cycle
  logic [31:0] pa, pb;
  logic [63:0] pp, acc_add;
  always_comb begin
    pa = part_r[0] ? mop_r[63:32] : mop_r[31:0];
    pb = part_r[1] ? MIX_M[63:32] : MIX_M[31:0];
    pp = pa * pb;
    case (part_r)
      2'd0:    acc_add = pp;
      2'd3:    acc_add = 64'd0;
      default: acc_add = {pp[31:0], 32'd0};
    endcase
  end

  logic [BATCH_BITS-1:0] batch_c;
  logic [SLOT_BITS-1:0] nxt_ptr;
  logic occ;
  always_comb begin
    batch_c = (in_word.batch_size > BATCH_BITS'(MAX_BATCH)) ? BATCH_BITS'(MAX_BATCH)
                                                            : in_word.batch_size;
    nxt_ptr = ptr_r + 1'b1;
    occ = (rd_data_r != SLOT_EMPTY) && (rd_data_r != SLOT_TOMB);
  end

  always_comb begin
    state_nxt = state_r; ptr_nxt = ptr_r; hand_nxt = hand_r; free_nxt = free_r;
    cnt_nxt = cnt_r; have_free_nxt = have_free_r; found_nxt = found_r;
    op_nxt = op_r; pid_nxt = pid_r; acc_nxt = acc_r; h_nxt = h_r;
    mstep_nxt = mstep_r; part_nxt = part_r; mop_nxt = mop_r;
    ov_nxt = 1'b0; ow_nxt = ow_r;
    rd_en = 1'b0; rd_addr = ptr_r;
    wr_en = 1'b0; wr_addr = ptr_r; wr_data = SLOT_EMPTY;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        ptr_nxt = nxt_ptr;
        if (ptr_r == SLOT_BITS'(SLOT_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_word.operation;
          pid_nxt = in_word.page_number;
          ow_nxt = '{status: ST_NO, candidate_page: 64'd0, has_candidate: 1'b0,
                     last: 1'b1};
          found_nxt = 1'b0;
          have_free_nxt = 1'b0;
          cnt_nxt = '0;
          if (in_word.operation == OP_SWEEP) begin
            hand_nxt = hand_r + SLOT_BITS'(batch_c);
            ptr_nxt = hand_r + SLOT_BITS'(batch_c);
            cnt_nxt = (SLOT_BITS+1)'(batch_c);
            if (batch_c == '0) ov_nxt = 1'b1;
            else state_nxt = S_SWEEP_RD;
          end else if (in_word.page_number == SLOT_EMPTY ||
                       in_word.page_number == SLOT_TOMB) begin
            ov_nxt = 1'b1;
          end else begin
            mop_nxt = in_word.page_number;
            acc_nxt = '0; part_nxt = '0; mstep_nxt = '0;
            h_nxt = MIX_SEED;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_nxt = acc_r + acc_add;
        part_nxt = part_r + 1'b1;
        if (part_r == 2'd3) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        part_nxt = '0;
        acc_nxt = '0;
        mstep_nxt = mstep_r + 1'b1;
        state_nxt = S_MUL;
        case (mstep_r)
          3'd0: mop_nxt = acc_r ^ (acc_r >> 47);
          3'd1: begin
            h_nxt = h_r ^ acc_r;
            mop_nxt = h_r ^ acc_r;
          end
          3'd2: mop_nxt = acc_r ^ (acc_r >> 47);
          default: begin
            h_nxt = acc_r ^ (acc_r >> 47);
            ptr_nxt = h_nxt[SLOT_BITS-1:0];
            state_nxt = S_PROBE_RD;
          end
        endcase
      end
      S_PROBE_RD: begin
        rd_en = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = S_PROBE_RD;
        ptr_nxt = nxt_ptr;
        cnt_nxt = cnt_r + 1'b1;
        case (op_r)
          OP_CONTAINS: begin
            if (rd_data_r == SLOT_EMPTY) begin
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end else if (rd_data_r == pid_r) begin
              ow_nxt.status = ST_OK; ov_nxt = 1'b1; state_nxt = S_IDLE;
            end
          end
          OP_INSERT: begin
            if (rd_data_r == pid_r) begin
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end else if (!occ) begin
              if (!have_free_r) begin
                have_free_nxt = 1'b1; free_nxt = ptr_r;
              end
              if (rd_data_r == SLOT_EMPTY) state_nxt = S_WRITE;
            end
          end
          default: begin
            if (rd_data_r == SLOT_EMPTY) begin
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end else if (rd_data_r == pid_r) begin
              wr_en = 1'b1; wr_data = SLOT_TOMB;
              ow_nxt.status = ST_OK; ov_nxt = 1'b1; state_nxt = S_IDLE;
            end
          end
        endcase
        if (state_nxt == S_PROBE_RD && cnt_r == (SLOT_BITS+1)'(SLOT_COUNT - 1)) begin
          if (op_r == OP_INSERT) state_nxt = S_WRITE;
          else begin
            if (op_r == OP_REMOVE) ow_nxt.status = ST_FULL;
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end
      end
      S_WRITE: begin
        if (have_free_r) begin
          wr_en = 1'b1; wr_addr = free_r; wr_data = pid_r;
          ow_nxt.status = ST_OK;
        end else ow_nxt.status = ST_FULL;
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_SWEEP_RD: begin
        rd_en = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        ptr_nxt = nxt_ptr;
        cnt_nxt = cnt_r - 1'b1;
        // a pending candidate is emitted once the next occupied slot or the end is known
        if (occ) begin
          if (found_r) begin
            ow_nxt.last = 1'b0; ov_nxt = 1'b1;
          end
          found_nxt = 1'b1;
          pid_nxt = rd_data_r;
        end
        if (cnt_r == (SLOT_BITS+1)'(1)) state_nxt = (occ && found_r) ? S_TAIL : S_IDLE;
        else state_nxt = S_SWEEP_RD;
      end
      S_TAIL: begin
        ow_nxt = '{status: ST_OK, candidate_page: pid_r, has_candidate: 1'b1,
                   last: 1'b1};
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_SWEEP && occ && found_r) begin
      ow_nxt.status = ST_OK; ow_nxt.candidate_page = pid_r; ow_nxt.has_candidate = 1'b1;
    end
    if (state_r == S_SWEEP && cnt_r == (SLOT_BITS+1)'(1) && !(occ && found_r)) begin
      ov_nxt = 1'b1;
      ow_nxt.last = 1'b1;
      if (occ || found_r) begin
        ow_nxt.status = ST_OK;
        ow_nxt.candidate_page = occ ? rd_data_r : pid_r;
        ow_nxt.has_candidate = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r <= '0;
      hand_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      hand_r <= hand_nxt;
      ov_r <= ov_nxt;
    end
    free_r <= free_nxt; cnt_r <= cnt_nxt; have_free_r <= have_free_nxt;
    found_r <= found_nxt; op_r <= op_nxt; pid_r <= pid_nxt; acc_r <= acc_nxt;
    h_r <= h_nxt; mstep_r <= mstep_nxt; part_r <= part_nxt; mop_r <= mop_nxt;
    ow_r <= ow_nxt;
  end

  assign out_valid = ov_r;
  assign out_word  = ow_r;
endmodule
